[design/polygon_point_inside_test_unit_defines.svh]
// Assertion macros shared by the polygon point test design.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef POLYGON_POINT_INSIDE_TEST_UNIT_DEFINES_SVH
`define POLYGON_POINT_INSIDE_TEST_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define PPIT_ASSERT_HOLD(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PPIT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PPIT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ppit_pkg.sv]
`timescale 1ns / 1ps
package ppit_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int VCOUNT_W     = 6;
  localparam int COUNT_OUT_W  = 6;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 6'd3;

  // Far end of the test segment is x = 10000.0 in Q6.10; the segment rises by 10 LSB.
  localparam int FAR_X_LSB  = 10240000;
  localparam int RAY_DY_LSB = 10;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [4:0]                vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic                   inside_res;
    logic [COUNT_OUT_W-1:0] crossing_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  // Travels with each vertex read out of the store.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } edge_tag_t;

  // One edge decision from the crossing pipeline.
  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } cross_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

[design/ppit_ram.sv]
`timescale 1ns / 1ps
module ppit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[design/ppit_cross.sv]
`timescale 1ns / 1ps
module ppit_cross import ppit_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] pt_x,
  input  logic signed [COORD_W-1:0] pt_y,
  input  vertex_t                   vtx,
  input  edge_tag_t                 tag,
  output cross_res_t                res
);

  // Coordinate differences, far-x distance, per-vertex and per-edge sums.
  localparam int DW = COORD_W + 1;
  localparam int WW = $clog2(FAR_X_LSB + 2 ** (COORD_W - 1)) + 1;
  localparam int SW = WW + DW + 1;
  localparam int PW = 2 * DW;

  // Two-bit code of a three-valued sign: {negative, zero}.
  function automatic logic [1:0] sign_code(input logic signed [SW-1:0] v);
    sign_code = {v < 0, v == 0};
  endfunction

  vertex_t               prev_r;
  logic signed [WW-1:0]  w;
  logic signed [DW-1:0]  dx, dy, a1, b1, a2, b2;
  logic signed [SW-1:0]  ms, tdx, ms_r, tdx_r;
  logic signed [PW-1:0]  m1, m2, m1_r, m2_r;
  logic signed [SW-1:0]  s_cur, c_ext, s2_s_r, s2_c_r, s_u_r, d;
  edge_tag_t             s1_r, s2_r;
  cross_res_t            res_r;
  logic                  hit;

  // Stage 1: the side of the test segment a vertex lies on is
  // W*dy - 10*dx, and the edge orientation of the query point is a cross
  // product of the previous vertex and this one.
  always_comb begin
    w   = WW'(FAR_X_LSB) - WW'(pt_x);
    dx  = DW'(vtx.x) - DW'(pt_x);
    dy  = DW'(vtx.y) - DW'(pt_y);
    ms  = SW'(w) * SW'(dy);
    tdx = SW'(dx) * SW'(RAY_DY_LSB);
    a1  = DW'(prev_r.x) - DW'(pt_x);
    b1  = DW'(vtx.y) - DW'(prev_r.y);
    a2  = DW'(prev_r.y) - DW'(pt_y);
    b2  = DW'(vtx.x) - DW'(prev_r.x);
    m1  = PW'(a1) * PW'(b1);
    m2  = PW'(a2) * PW'(b2);
  end

  // Stage 2 and stage 3. The far-point orientation of the edge equals the
  // query-point orientation plus the difference of the two vertex sides.
  always_comb begin
    s_cur = ms_r - tdx_r;
    c_ext = SW'(m1_r) - SW'(m2_r);
    d     = s2_c_r + s_u_r - s2_s_r;
    hit   = !s2_r.first
            && (sign_code(s_u_r) != sign_code(s2_s_r))
            && (sign_code(s2_c_r) != sign_code(d));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r  <= '0;
      s2_r  <= '0;
      res_r <= '0;
    end else begin
      s1_r  <= tag;
      s2_r  <= s1_r;
      res_r <= '{valid: s2_r.valid, last: s2_r.last, hit: s2_r.valid && hit};
    end
  end

  always_ff @(posedge clk) begin
    if (tag.valid) begin
      prev_r <= vtx;
      ms_r   <= ms;
      tdx_r  <= tdx;
      m1_r   <= m1;
      m2_r   <= m2;
    end
    if (s1_r.valid) begin
      s2_s_r <= s_cur;
      s2_c_r <= c_ext;
    end
    if (s2_r.valid) begin
      s_u_r <= s2_s_r;
    end
  end

  assign res = res_r;

endmodule

[design/polygon_point_inside_test_unit.sv]
`timescale 1ns / 1ps
// Point-in-polygon unit by crossing number.
// Input channel (in_valid, in_stall, in_data): an item either loads one vertex
// into its slot or asks whether a point lies inside the closed polygon formed
// by the first vertex_count slots. Output channel (out_valid, out_stall,
// out_data): one item per query with the parity and the number of edges that
// the test segment from the point to x = 10000.0 crossed. Loads give no item.
// Configuration: cfg_wr_en writes cfg_wr_data into vertex_count; write it only
// while the unit is idle.
// A load is written into its slot as it is accepted and leaves the unit idle.
// A query over n vertices reads n + 1 slots from the vertex memory, one per
// cycle (the first slot again to close the polygon), so the single memory port
// sets the rate; the result passes the registered memory read and the three
// stage crossing pipeline, and no item is taken until the unit is idle again.
// A query with vertex_count of zero goes straight to the done state.
// A finished result waits in the output register while out_stall is high; a
// load or a new query is still taken then, and a second result waits in the
// unit until the first one is gone. Reset sets vertex_count to 3 and empties
// the unit; the vertex slots keep no reset value and must be loaded first.
`include "polygon_point_inside_test_unit_defines.svh"
module polygon_point_inside_test_unit import ppit_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [VCOUNT_W-1:0] cfg_wr_data
);

  state_t                    state_r, state_nxt;
  logic [VCOUNT_W-1:0]       vcount_r;
  logic [CNT_W-1:0]          n_eff, n_r, k_r, cnt_r, cnt_nxt;
  logic                      iss_done_r;
  logic signed [COORD_W-1:0] pt_x_r, pt_y_r;
  edge_tag_t                 tag_r;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r;

  logic                      in_acc, is_query, idx_ok, issue, out_free;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_addr, rd_addr;
  vertex_t                   ram_wdata, ram_rdata;
  cross_res_t                xo;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_query = (in_data.req_type == REQ_QUERY);
  assign out_free = !out_valid_r || !out_stall;

  // Counts above the table depth are saturated; loads past it are dropped.
  always_comb begin
    if (32'(vcount_r) > 32'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = CNT_W'(vcount_r);
    end
    idx_ok = (32'(in_data.vertex_index) < 32'(MAX_VERTICES));
  end

  // The read walk goes 0 .. n-1 and then back to slot 0 for the closing edge.
  assign issue     = (state_r == ST_RUN) && !iss_done_r;
  assign rd_addr   = (k_r == n_r) ? '0 : k_r[ADDR_W-1:0];
  assign ram_we    = in_acc && !is_query && idx_ok;
  assign ram_addr  = ram_we ? ADDR_W'(in_data.vertex_index) : rd_addr;
  assign ram_wdata = '{x: in_data.coord_x, y: in_data.coord_y};

  ppit_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ppit_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .pt_x  (pt_x_r),
    .pt_y  (pt_y_r),
    .vtx   (ram_rdata),
    .tag   (tag_r),
    .res   (xo)
  );

  // Sequencer: a query runs until the last edge leaves the pipeline, then the
  // count waits until the output register can take it.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          cnt_nxt   = '0;
          state_nxt = (n_eff == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (xo.valid && xo.hit) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (xo.valid && xo.last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= VCOUNT_RESET;
      out_valid_r <= 1'b0;
      iss_done_r  <= 1'b1;
      k_r         <= '0;
      tag_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      tag_r       <= '{valid: issue, first: (k_r == '0), last: (k_r == n_r)};
      if (in_acc && is_query) begin
        k_r        <= '0;
        iss_done_r <= 1'b0;
      end else if (issue) begin
        if (k_r == n_r) begin
          iss_done_r <= 1'b1;
        end else begin
          k_r <= k_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (in_acc && is_query) begin
      n_r    <= n_eff;
      pt_x_r <= in_data.coord_x;
      pt_y_r <= in_data.coord_y;
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= '{inside_res: cnt_r[0], crossing_count: COUNT_OUT_W'(cnt_r)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPIT_ASSERT_NEXT(a_query_starts_walk, in_acc && is_query && n_eff != '0, state_r == ST_RUN, "query with vertices did not start the walk")
  `PPIT_ASSERT_IMPL(a_count_bounded, state_r == ST_RUN, cnt_r <= n_r, "crossing count exceeds edge count")
  `PPIT_ASSERT_IMPL(a_edge_only_in_run, xo.valid, state_r == ST_RUN, "edge decision outside a query")
  `PPIT_ASSERT_NEXT(a_done_loads_output, state_r == ST_DONE && out_free, out_valid && state_r == ST_IDLE, "finished query not handed to the output")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ppit_pkg::*;

  // Cycles to let the unit finish internal work once the last result has arrived.
  // This covers a query over the full table, so it also leaves room for a load
  // or a second query that is still in flight.
  localparam int SETTLE_CYCLES = 64;
  // Cycles with no item moving on either channel before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  // Length of the deliberate receiver hold-off that fills the unit up.
  localparam int HOLD_CYCLES   = 400;
  // Stimulus stops once this many random items have been offered.
  localparam int RANDOM_ITEMS  = 860;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_wr_en;
  logic [VCOUNT_W-1:0] cfg_wr_data;

  // Predictor state: our own copy of the vertex table and the vertex count.
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  logic [VCOUNT_W-1:0]       vertex_count_cfg = VCOUNT_RESET;

  // Answers the unit owes us, oldest query first.
  out_item_t pending_results [$];
  out_item_t expected_head;
  int        fail_count = 0;

  // Idle control. The sender side is read by send_item, the receiver side by the
  // stall generator. A hold-off is asked for by bumping holds_requested.
  bit send_idle = 1'b0;
  bit stall_on  = 1'b0;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int stall_run       = 0;
  int stall_roll;
  int idle_cycles     = 0;

  polygon_point_inside_test_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Crossing-number predictor.
  // ---------------------------------------------------------------------------

  // Sign of the cross product (a - c) x (b - c). All terms fit comfortably in
  // 64 bits: differences stay below 2^25, so the products stay below 2^50.
  function automatic int orient_sign(input longint ax, input longint ay,
                                     input longint bx, input longint by,
                                     input longint cx, input longint cy);
    longint v;
    v = (ax - cx) * (by - cy) - (ay - cy) * (bx - cx);
    if (v < 0) return -1;
    if (v == 0) return 0;
    return 1;
  endfunction

  // Counts the polygon edges crossed by the segment from the query point to the
  // far point, walking edges i -> i+1 and closing the last vertex back to zero.
  function automatic out_item_t predict_query(input in_item_t q);
    longint    px, py, rx, ry, ux, uy, vx, vy;
    int        n, i, j, a, b, c, d, hits;
    out_item_t r;
    n  = (vertex_count_cfg > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_cfg);
    px = longint'($signed(q.coord_x));
    py = longint'($signed(q.coord_y));
    rx = longint'(FAR_X_LSB);
    ry = py + RAY_DY_LSB;
    hits = 0;
    for (i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      ux = longint'(poly_x[i]);
      uy = longint'(poly_y[i]);
      vx = longint'(poly_x[j]);
      vy = longint'(poly_y[j]);
      a  = orient_sign(px, py, rx, ry, ux, uy);
      b  = orient_sign(px, py, rx, ry, vx, vy);
      c  = orient_sign(ux, uy, vx, vy, px, py);
      d  = orient_sign(ux, uy, vx, vy, rx, ry);
      if (a != b && c != d) hits++;
    end
    r.inside_res     = hits[0];
    r.crossing_count = hits[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int rand_coord();
    return rand_between(-32768, 32767);
  endfunction

  // Coordinates built near the table edges can run past 16 bits; pin them.
  function automatic logic signed [COORD_W-1:0] sat16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic in_item_t make_item(input logic kind, input logic [4:0] idx,
                                         input int x, input int y);
    in_item_t it;
    it.req_type     = kind;
    it.vertex_index = idx;
    it.coord_x      = sat16(x);
    it.coord_y      = sat16(y);
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. A new item goes
  // straight onto the bus when no gap is wanted, so valid never drops and rises
  // within the same time step.
  task automatic send_item(input in_item_t item);
    int gap;
    int roll;
    gap = 0;
    if (send_idle) begin
      roll = $urandom_range(0, 99);
      if (roll >= 90) gap = rand_between(8, 40);
      else if (roll >= 60) gap = rand_between(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // The item is taken at this edge: update the table or queue the answer.
    if (item.req_type == REQ_QUERY) begin
      pending_results.push_back(predict_query(item));
    end else begin
      poly_x[item.vertex_index] = item.coord_x;
      poly_y[item.vertex_index] = item.coord_y;
    end
  endtask

  // Stops offering items until every owed result is back, then lets any trailing
  // load or internal work finish.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The count register may only change while the unit is idle.
  task automatic write_vertex_count(input logic [VCOUNT_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    vertex_count_cfg = value;
  endtask

  // Slots that a query reads under the current count; the unit saturates the
  // count at the table size.
  function automatic int slots_in_use();
    return (vertex_count_cfg > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count_cfg);
  endfunction

  // Loads slots 0 .. n-1 with one of three shapes: scattered points over the
  // whole range, a tight cluster (lots of collinear and horizontal edges), or a
  // square walked around its perimeter so that real inside regions exist.
  task automatic load_random_polygon(input int n);
    int style, spread, cx, cy, i, p, side, off, x, y;
    style = $urandom_range(0, 2);
    cx    = rand_between(-16384, 16383);
    cy    = rand_between(-16384, 16383);
    case ($urandom_range(0, 2))
      0: spread = 8;
      1: spread = 256;
      default: spread = 4096;
    endcase
    if (style == 2) spread = rand_between(64, 8000);
    for (i = 0; i < n; i++) begin
      case (style)
        0: begin
          x = rand_coord();
          y = rand_coord();
        end
        1: begin
          x = cx + rand_between(-spread, spread);
          y = cy + rand_between(-spread, spread);
        end
        default: begin
          p    = i * 8 * spread / n;
          side = p / (2 * spread);
          off  = p % (2 * spread);
          case (side)
            0: begin x = cx - spread + off; y = cy - spread;       end
            1: begin x = cx + spread;       y = cy - spread + off; end
            2: begin x = cx + spread - off; y = cy + spread;       end
            default: begin x = cx - spread; y = cy + spread - off; end
          endcase
        end
      endcase
      send_item(make_item(REQ_LOAD, 5'(i), x, y));
    end
  endtask

  // Query points are drawn mostly around the loaded polygon: near a vertex, on a
  // vertex, level with a vertex to its left, and halfway between two vertices.
  function automatic in_item_t random_query(input int n);
    int roll, a, b, x, y;
    roll = $urandom_range(0, 99);
    a    = (n > 0) ? $urandom_range(0, n - 1) : 0;
    b    = (n > 0) ? $urandom_range(0, n - 1) : 0;
    if (n == 0 || roll < 35) begin
      x = rand_coord();
      y = rand_coord();
    end else if (roll < 65) begin
      x = poly_x[a] + rand_between(-16, 16);
      y = poly_y[a] + rand_between(-16, 16);
    end else if (roll < 75) begin
      x = poly_x[a];
      y = poly_y[a];
    end else if (roll < 85) begin
      x = poly_x[a] - rand_between(0, 4096);
      y = poly_y[a];
    end else begin
      x = (poly_x[a] + poly_x[b]) / 2;
      y = (poly_y[a] + poly_y[b]) / 2;
    end
    return make_item(REQ_QUERY, 5'($urandom_range(0, 31)), x, y);
  endfunction

  function automatic logic [VCOUNT_W-1:0] pick_vertex_count(input int phase);
    int roll;
    // The first phases walk the extremes, starting with a full table so that
    // every slot is loaded early on.
    case (phase)
      0: return 6'd32;
      1: return 6'd63;
      2: return 6'd33;
      3: return 6'd0;
      4: return 6'd1;
      5: return 6'd2;
      6: return 6'd3;
      default: begin
        roll = $urandom_range(0, 99);
        if (roll < 70) return 6'($urandom_range(3, 32));
        if (roll < 85) return 6'($urandom_range(0, 2));
        return 6'($urandom_range(33, 63));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Runs under the reset count of three. The triangle spans the full coordinate
  // range, and the queries sit at the origin, on its corners and on the range limits.
  task automatic test_extreme_triangle();
    send_item(make_item(REQ_LOAD, 5'd0, -32768, -32768));
    send_item(make_item(REQ_LOAD, 5'd1, 32767, -32768));
    send_item(make_item(REQ_LOAD, 5'd2, 0, 32767));
    send_item(make_item(REQ_QUERY, 5'd31, 0, 0));
    send_item(make_item(REQ_QUERY, 5'd0, -32768, -32768));
    send_item(make_item(REQ_QUERY, 5'd21, 32767, 32767));
    send_item(make_item(REQ_QUERY, 5'd10, 0, -32768));
    send_item(make_item(REQ_QUERY, 5'd31, 0, 32767));
    send_item(make_item(REQ_QUERY, 5'd5, -32768, 32767));
    send_item(make_item(REQ_QUERY, 5'd26, 32767, -32768));
  endtask

  // A small triangle with points on its edges, left of a vertex on the same
  // row, and just under a vertex.
  task automatic test_small_triangle();
    send_item(make_item(REQ_LOAD, 5'd0, 0, 0));
    send_item(make_item(REQ_LOAD, 5'd1, 4096, 0));
    send_item(make_item(REQ_LOAD, 5'd2, 0, 4096));
    send_item(make_item(REQ_QUERY, 5'd3, 1024, 1024));
    send_item(make_item(REQ_QUERY, 5'd0, 0, 2048));
    send_item(make_item(REQ_QUERY, 5'd0, 2048, 0));
    send_item(make_item(REQ_QUERY, 5'd0, -1024, 0));
    send_item(make_item(REQ_QUERY, 5'd0, 4096, -10));
  endtask

  // No edges at all, then the degenerate polygons of one and two vertices, then a triangle.
  task automatic test_small_counts();
    write_vertex_count(6'd0);
    send_item(make_item(REQ_QUERY, 5'd0, 1024, 1024));
    write_vertex_count(6'd1);
    send_item(make_item(REQ_QUERY, 5'd0, -5, 0));
    write_vertex_count(6'd2);
    send_item(make_item(REQ_QUERY, 5'd0, 100, -5));
    write_vertex_count(6'd3);
    send_item(make_item(REQ_QUERY, 5'd0, 1024, 1024));
  endtask

  // Each phase sets a count, loads a fresh polygon into every slot it reads,
  // then mostly queries it with a few stray loads mixed in. Idling on either
  // side is switched per phase so some phases run flat out.
  task automatic test_random_phases();
    int sent, phase, n, nq, k, idle_mode;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_vertex_count(pick_vertex_count(phase));
      idle_mode = $urandom_range(0, 3);
      send_idle = idle_mode[0];
      stall_on <= idle_mode[1];
      n = slots_in_use();
      load_random_polygon(n);
      sent += n;
      nq = rand_between(15, 40);
      for (k = 0; k < nq; k++) begin
        if ($urandom_range(0, 99) < 8)
          send_item(make_item(REQ_LOAD, 5'($urandom_range(0, 31)), rand_coord(), rand_coord()));
        else
          send_item(random_query(slots_in_use()));
        sent++;
      end
      phase++;
    end
  endtask

  // The receiver holds off for a long stretch while queries keep coming, so the
  // output register and the internal result slot fill and the input stalls.
  task automatic test_output_holdoff();
    int k;
    write_vertex_count(6'd32);
    send_idle = 1'b0;
    load_random_polygon(MAX_VERTICES);
    holds_requested <= holds_requested + 1;
    for (k = 0; k < 12; k++) send_item(random_query(MAX_VERTICES));
    send_idle = 1'b1;
    stall_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus the counted hold-off on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      holds_served <= holds_requested;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      // Mostly short open or stalled stretches, now and then a long stall.
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 3);
      end else if (stall_roll < 90) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(9, 39);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest answer
  // the predictor queued.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result with no query pending: inside_res=%0d crossing_count=%0d",
               out_data.inside_res, out_data.crossing_count);
        fail_count++;
      end else begin
        expected_head = pending_results.pop_front();
        if (out_data.inside_res !== expected_head.inside_res) begin
          $error("inside_res mismatch: expected %0d, actual %0d",
                 expected_head.inside_res, out_data.inside_res);
          fail_count++;
        end
        if (out_data.crossing_count !== expected_head.crossing_count) begin
          $error("crossing_count mismatch: expected %0d, actual %0d",
                 expected_head.crossing_count, out_data.crossing_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("polygon_point_inside_test_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, directed tests, random phases, the hold-off, drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_triangle();
    test_small_triangle();
    test_small_counts();
    test_random_phases();
    test_output_holdoff();

    drain_results();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("polygon_point_inside_test_unit regression: pass");
    end else begin
      $display("polygon_point_inside_test_unit regression: fail");
    end
    $finish;
  end

endmodule

[polygon_point_inside_test_unit.f]
+incdir+design
design/ppit_pkg.sv
design/ppit_ram.sv
design/ppit_cross.sv
design/polygon_point_inside_test_unit.sv
tb/testbench.sv
